// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the time switch relay controller.
// Depends on nothing; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/tsw_pkg.sv -----
// Types and constants of the time switch relay controller.
// Used by tsw_cfg, tsw_core and the top level; depends on nothing.
package tsw_pkg;

	localparam int APB_AW = 5;

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_ON_TIME  = 3'd0;
	localparam reg_idx_t REG_OFF_TIME = 3'd1;
	localparam reg_idx_t REG_HEAT_LO  = 3'd2;
	localparam reg_idx_t REG_HEAT_HI  = 3'd3;
	localparam reg_idx_t REG_LIGHT_LO = 3'd4;
	localparam reg_idx_t REG_LIGHT_HI = 3'd5;

	localparam logic [16:0] ON_TIME_RST  = 17'd73733;
	localparam logic [16:0] OFF_TIME_RST = 17'd73738;
	localparam logic [9:0]  HEAT_LO_RST  = 10'd50;
	localparam logic [9:0]  HEAT_HI_RST  = 10'd100;
	localparam logic [9:0]  LIGHT_LO_RST = 10'd300;
	localparam logic [9:0]  LIGHT_HI_RST = 10'd600;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_SET  = 1'b1
	} op_t;

	localparam logic [1:0] COMP_HOURS   = 2'd0;
	localparam logic [1:0] COMP_MINUTES = 2'd1;
	localparam logic [1:0] COMP_SECONDS = 2'd2;

	localparam logic [4:0] HOURS_MAX  = 5'd23;
	localparam logic [5:0] MINSEC_MAX = 6'd59;
	localparam logic [4:0] HOURS_RST  = 5'd18;

	typedef struct packed {
		logic [16:0] on_time;
		logic [16:0] off_time;
		logic [9:0]  heat_lo;
		logic [9:0]  heat_hi;
		logic [9:0]  light_lo;
		logic [9:0]  light_hi;
	} cfg_t;

	typedef struct packed {
		op_t                op;
		logic [1:0]         component;
		logic [6:0]         set_value;
		logic [15:0]        light_level;
		logic signed [9:0]  temperature;
	} item_t;

	typedef struct packed {
		logic       relay_time;
		logic       relay_light;
		logic       relay_heat;
		logic [4:0] clock_hours;
		logic [5:0] clock_minutes;
		logic [5:0] clock_seconds;
	} result_t;

endpackage

// ----- rtl/time_switch_window_relay_controller.sv -----
// Time switch and window relay controller: one result word per input word,
// one word per cycle sustained while the output does not stall.
// An input register stages the word; the clock update, time compare and
// both window compares then run combinationally into the output register,
// which holds the result while the output stalls; the stall reaches s_tready combinationally.
// Config (APB, regs at 4*i) must be written only while idle; the block does not enforce it.
// Depends on tsw_pkg, tsw_cfg, tsw_core and assert_macros.svh.
`include "assert_macros.svh"

module time_switch_window_relay_controller import tsw_pkg::*; #(
	parameter int TICKS_PER_SECOND = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	// APB config
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	// input stream
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [39:0]       s_tdata,  // component[1:0] set_value[8:2] light_level[24:9]
	                                    // temperature[34:25], zero[39:35]
	input  logic              s_tuser,  // op[0]
	// result stream
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [23:0]       m_tdata   // relay_time[0] relay_light[1] relay_heat[2]
	                                    // clock_hours[7:3] clock_minutes[13:8]
	                                    // clock_seconds[19:14], zero[23:20]
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance, step;
	result_t result;
	result_t out_q;
	logic    out_valid_q;

	tsw_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign advance  = !out_valid_q || m_tready;
	assign step     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.op          <= op_t'(s_tuser);
			item_s1.component   <= s_tdata[1:0];
			item_s1.set_value   <= s_tdata[8:2];
			item_s1.light_level <= s_tdata[24:9];
			item_s1.temperature <= s_tdata[34:25];
		end
	end

	tsw_core #(
		.TICKS_PER_SECOND (TICKS_PER_SECOND)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.step   (step),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			out_q <= result;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_q.clock_seconds, out_q.clock_minutes, out_q.clock_hours,
	                   out_q.relay_heat, out_q.relay_light, out_q.relay_time};

	`ASSERT_IMPL(a_ready_when_out_free, clk, arst_n, !out_valid_q, s_tready)
	`ASSERT_NEXT(a_step_fills_out, clk, arst_n, step, out_valid_q)
	`ASSERT_NEXT(a_staged_word_held, clk, arst_n, valid_s1 && !advance, valid_s1)
	`ASSERT_IMPL(a_clock_in_range, clk, arst_n, out_valid_q,
		(out_q.clock_hours <= HOURS_MAX) &&
		(out_q.clock_minutes <= MINSEC_MAX) &&
		(out_q.clock_seconds <= MINSEC_MAX))

endmodule

// ----- rtl/tsw_cfg.sv -----
// APB register file of the time switch relay controller: on/off times and
// window bounds. Depends on tsw_pkg.
module tsw_cfg import tsw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[APB_AW-1:2];
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.on_time  <= ON_TIME_RST;
			cfg_q.off_time <= OFF_TIME_RST;
			cfg_q.heat_lo  <= HEAT_LO_RST;
			cfg_q.heat_hi  <= HEAT_HI_RST;
			cfg_q.light_lo <= LIGHT_LO_RST;
			cfg_q.light_hi <= LIGHT_HI_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_ON_TIME:  cfg_q.on_time  <= pwdata[16:0];
				REG_OFF_TIME: cfg_q.off_time <= pwdata[16:0];
				REG_HEAT_LO:  cfg_q.heat_lo  <= pwdata[9:0];
				REG_HEAT_HI:  cfg_q.heat_hi  <= pwdata[9:0];
				REG_LIGHT_LO: cfg_q.light_lo <= pwdata[9:0];
				REG_LIGHT_HI: cfg_q.light_hi <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ON_TIME:  prdata = {15'd0, cfg_q.on_time};
			REG_OFF_TIME: prdata = {15'd0, cfg_q.off_time};
			REG_HEAT_LO:  prdata = {22'd0, cfg_q.heat_lo};
			REG_HEAT_HI:  prdata = {22'd0, cfg_q.heat_hi};
			REG_LIGHT_LO: prdata = {22'd0, cfg_q.light_lo};
			REG_LIGHT_HI: prdata = {22'd0, cfg_q.light_hi};
			default:      prdata = 32'd0;
		endcase
	end

endmodule

// ----- rtl/tsw_core.sv -----
// Clock state, time switch and window comparators. Computes the result of
// the staged word and commits the new state on step. Depends on tsw_pkg.
module tsw_core import tsw_pkg::*; #(
	parameter int TICKS_PER_SECOND = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  item_t   item,
	input  logic    step,
	output result_t result
);

	localparam int TW = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;

	logic [TW-1:0] tick_q, tick_n;
	result_t       state_q, nxt;
	logic          wrap, on_hit, off_hit;

	// open interval; reversed when end is not above start
	function automatic logic in_window(logic signed [16:0] x, logic signed [16:0] s,
	                                   logic signed [16:0] e);
		if (e > s)
			return (x > s) && (x < e);
		return (x > e) && (x < s);
	endfunction

	assign wrap = (tick_q == TW'(TICKS_PER_SECOND - 1));

	always_comb begin
		nxt    = state_q;
		tick_n = tick_q;
		if (item.op == OP_SET) begin
			// state stays in range, so only the written field needs the check
			unique case (item.component)
				COMP_HOURS:
					nxt.clock_hours = (item.set_value > 7'(HOURS_MAX)) ? 5'd0
					                  : item.set_value[4:0];
				COMP_MINUTES:
					nxt.clock_minutes = (item.set_value > 7'(MINSEC_MAX)) ? 6'd0
					                    : item.set_value[5:0];
				COMP_SECONDS:
					nxt.clock_seconds = (item.set_value > 7'(MINSEC_MAX)) ? 6'd0
					                    : item.set_value[5:0];
				default: ;
			endcase
		end else begin
			tick_n = wrap ? '0 : tick_q + TW'(1);
			if (wrap) begin
				if (state_q.clock_seconds == MINSEC_MAX) begin
					nxt.clock_seconds = 6'd0;
					if (state_q.clock_minutes == MINSEC_MAX) begin
						nxt.clock_minutes = 6'd0;
						nxt.clock_hours = (state_q.clock_hours == HOURS_MAX) ? 5'd0
						                  : state_q.clock_hours + 5'd1;
					end else begin
						nxt.clock_minutes = state_q.clock_minutes + 6'd1;
					end
				end else begin
					nxt.clock_seconds = state_q.clock_seconds + 6'd1;
				end
			end
			if (off_hit)
				nxt.relay_time = 1'b0;
			else if (on_hit)
				nxt.relay_time = 1'b1;
			nxt.relay_heat  = in_window(17'(item.temperature),
			                            $signed({7'd0, cfg.heat_lo}),
			                            $signed({7'd0, cfg.heat_hi}));
			nxt.relay_light = in_window($signed({1'b0, item.light_level}),
			                            $signed({7'd0, cfg.light_lo}),
			                            $signed({7'd0, cfg.light_hi}));
		end
	end

	// compare against the clock after the tick update
	always_comb begin
		logic [4:0] h;
		logic [5:0] m;
		logic [5:0] s;
		h = state_q.clock_hours;
		m = state_q.clock_minutes;
		s = state_q.clock_seconds;
		if (wrap) begin
			if (s == MINSEC_MAX) begin
				s = 6'd0;
				if (m == MINSEC_MAX) begin
					m = 6'd0;
					h = (h == HOURS_MAX) ? 5'd0 : h + 5'd1;
				end else begin
					m = m + 6'd1;
				end
			end else begin
				s = s + 6'd1;
			end
		end
		on_hit  = (cfg.on_time  == {h, m, s});
		off_hit = (cfg.off_time == {h, m, s});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q                <= '0;
			state_q.relay_time    <= 1'b0;
			state_q.relay_light   <= 1'b0;
			state_q.relay_heat    <= 1'b0;
			state_q.clock_hours   <= HOURS_RST;
			state_q.clock_minutes <= 6'd0;
			state_q.clock_seconds <= 6'd0;
		end else if (step) begin
			tick_q  <= tick_n;
			state_q <= nxt;
		end
	end

	assign result = nxt;

endmodule
